>>> hw/rtl/ufcef_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufcef_pkg
// Shared types and constants for the union-find cycle edge filter.
// ----------------------------------------------------------------------------
package ufcef_pkg;

  localparam int unsigned MaxVerticesDef = 1024;
  localparam int unsigned CountW         = 11;
  localparam int unsigned VertW          = 10;
  localparam int unsigned WeightW        = 16;
  localparam int unsigned TotalW         = 32;
  localparam int unsigned RankW          = 4;
  localparam logic [RankW-1:0] RankMax   = 4'd15;
  localparam logic [CountW-1:0] CountRst = 11'd1024;

  typedef struct packed {
    logic                      mode;
    logic [VertW-1:0]          from_vertex;
    logic [VertW-1:0]          to_vertex;
    logic signed [WeightW-1:0] weight;
  } ufcef_in_t;

  typedef struct packed {
    logic                     edge_dropped;
    logic signed [TotalW-1:0] dropped_total;
    logic                     vertex_out_of_range;
  } ufcef_out_t;

  // command handed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_EDGE  = 2'b00,
    CMD_CLEAR = 2'b01,
    CMD_FLAG  = 2'b10
  } ufcef_cmd_e;

endpackage

>>> hw/rtl/ufcef_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufcef_front
// Accepts items, range-checks endpoints and pushes a command into a short queue.
// ----------------------------------------------------------------------------
module ufcef_front import ufcef_pkg::*; #(
  parameter int unsigned MaxVertices = MaxVerticesDef,
  parameter int unsigned VIdxW       = $clog2(MaxVertices)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  ufcef_in_t         item_i,
  input  logic [CountW-1:0] count_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output ufcef_cmd_e        cmd_o,
  output logic [VIdxW-1:0]  a_o,
  output logic [VIdxW-1:0]  b_o,
  output logic [CountW-1:0] cnt_o,
  output logic signed [WeightW-1:0] w_o
);

  localparam int unsigned Depth = 2;

  typedef struct packed {
    ufcef_cmd_e                cmd;
    logic [VIdxW-1:0]          a;
    logic [VIdxW-1:0]          b;
    logic [CountW-1:0]         cnt;
    logic signed [WeightW-1:0] w;
  } qent_t;

  qent_t       q_mem_q [Depth];
  logic        wp_q, rp_q;
  logic [1:0]  lvl_q;
  qent_t       ent;
  logic [16:0] cnt_eff;
  logic [16:0] a_ext, b_ext;

  always_comb begin
    cnt_eff = (17'(count_i) > 17'(MaxVertices)) ? 17'(MaxVertices) : 17'(count_i);
    a_ext   = 17'(item_i.from_vertex);
    b_ext   = 17'(item_i.to_vertex);
    ent.a   = VIdxW'(item_i.from_vertex);
    ent.b   = VIdxW'(item_i.to_vertex);
    ent.w   = item_i.weight;
    ent.cnt = CountW'(cnt_eff);
    if (item_i.mode) begin
      ent.cmd = CMD_CLEAR;
    end else if (a_ext >= cnt_eff || b_ext >= cnt_eff) begin
      ent.cmd = CMD_FLAG;
    end else begin
      ent.cmd = CMD_EDGE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) q_mem_q[wp_q] <= ent;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      lvl_q <= 2'd0;
    end else begin
      if (take_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      lvl_q <= lvl_q + 2'(take_i) - 2'(pop_i);
    end
  end

  assign full_o  = (lvl_q == 2'(Depth));
  assign empty_o = (lvl_q == 2'd0);
  assign cmd_o   = q_mem_q[rp_q].cmd;
  assign a_o     = q_mem_q[rp_q].a;
  assign b_o     = q_mem_q[rp_q].b;
  assign cnt_o   = q_mem_q[rp_q].cnt;
  assign w_o     = q_mem_q[rp_q].w;

endmodule

>>> hw/rtl/ufcef_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufcef_back
// Runs the reset init sweep, finds, compression, union by rank and clear sweeps on the parent and rank memories.
// ----------------------------------------------------------------------------
module ufcef_back import ufcef_pkg::*; #(
  parameter int unsigned MaxVertices = MaxVerticesDef,
  parameter int unsigned VIdxW       = $clog2(MaxVertices)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  ufcef_cmd_e        cmd_i,
  input  logic [VIdxW-1:0]  a_i,
  input  logic [VIdxW-1:0]  b_i,
  input  logic [CountW-1:0] cnt_i,
  input  logic signed [WeightW-1:0] w_i,
  output logic              pop_o,
  output logic              init_o,
  output logic              res_valid_o,
  output ufcef_out_t        res_o
);

  typedef enum logic [10:0] {
    ST_INIT  = 11'b00000000001,
    ST_IDLE  = 11'b00000000010,
    ST_CLR   = 11'b00000000100,
    ST_FRD   = 11'b00000001000,
    ST_FCHK  = 11'b00000010000,
    ST_CRD   = 11'b00000100000,
    ST_CWR   = 11'b00001000000,
    ST_URD   = 11'b00010000000,
    ST_UCHK  = 11'b00100000000,
    ST_UWR   = 11'b01000000000,
    ST_DONE  = 11'b10000000000
  } st_e;

  st_e st_q, st_d;

  logic [VIdxW-1:0] par_mem [MaxVertices];
  logic [RankW-1:0] rnk_mem [MaxVertices];

  logic [VIdxW-1:0] raddr, waddr, pdata_q, pwdata;
  logic [RankW-1:0] rdata_q, rwdata;
  logic             pwe, rwe;

  logic [VIdxW:0]   idx_q, idx_d;       // sweep counter, holds the depth itself
  logic [VIdxW-1:0] cur_q, cur_d;       // walking pointer
  logic [VIdxW-1:0] ra_q, ra_d, rb_q, rb_d;
  logic [RankW-1:0] rka_q, rka_d;
  logic             side_q, side_d;     // 0: from side, 1: to side
  logic             dropped_q, dropped_d, flag_q, flag_d;
  logic signed [TotalW-1:0] sum_q, sum_d;
  logic [VIdxW-1:0] start_v;

  always_ff @(posedge clk_i) begin
    if (pwe) par_mem[waddr] <= pwdata;
    if (rwe) rnk_mem[waddr] <= rwdata;
    pdata_q <= par_mem[raddr];
    rdata_q <= rnk_mem[raddr];
  end

  assign start_v = side_q ? b_i : a_i;

  always_comb begin
    st_d = st_q; idx_d = idx_q; cur_d = cur_q; ra_d = ra_q; rb_d = rb_q;
    rka_d = rka_q; side_d = side_q; dropped_d = dropped_q; flag_d = flag_q;
    sum_d = sum_q;
    raddr = cur_q; waddr = cur_q; pwdata = ra_q; rwdata = '0;
    pwe = 1'b0; rwe = 1'b0; pop_o = 1'b0;
    case (st_q)
      ST_INIT: begin
        waddr = idx_q[VIdxW-1:0]; pwdata = idx_q[VIdxW-1:0];
        pwe = 1'b1; rwe = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == (VIdxW+1)'(MaxVertices - 1)) st_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (!empty_i) begin
          dropped_d = 1'b0; flag_d = 1'b0;
          case (cmd_i)
            CMD_CLEAR: begin
              idx_d = '0; sum_d = '0;
              st_d = (cnt_i == '0) ? ST_DONE : ST_CLR;
            end
            CMD_FLAG: begin
              flag_d = 1'b1; st_d = ST_DONE;
            end
            default: begin
              side_d = 1'b0; cur_d = a_i; st_d = ST_FRD;
            end
          endcase
        end
      end
      ST_CLR: begin
        waddr = idx_q[VIdxW-1:0]; pwdata = idx_q[VIdxW-1:0];
        pwe = 1'b1; rwe = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q + 1'b1 >= (VIdxW+1)'(cnt_i)) st_d = ST_DONE;
      end
      ST_FRD: begin
        raddr = cur_q; st_d = ST_FCHK;
      end
      ST_FCHK: begin
        if (pdata_q == cur_q) begin
          // root found, walk again from the start and point nodes at it
          if (side_q) rb_d = cur_q; else ra_d = cur_q;
          cur_d = start_v; st_d = ST_CRD;
        end else begin
          cur_d = pdata_q; st_d = ST_FRD;
        end
      end
      ST_CRD: begin
        if (cur_q == (side_q ? rb_q : ra_q)) begin
          if (!side_q) begin
            side_d = 1'b1; cur_d = b_i; st_d = ST_FRD;
          end else begin
            cur_d = ra_q; st_d = ST_URD;
          end
        end else begin
          raddr = cur_q; st_d = ST_CWR;
        end
      end
      ST_CWR: begin
        waddr = cur_q; pwdata = side_q ? rb_q : ra_q; pwe = 1'b1;
        cur_d = pdata_q; st_d = ST_CRD;
      end
      ST_URD: begin
        if (ra_q == rb_q) begin
          dropped_d = 1'b1;
          sum_d = sum_q + TotalW'(w_i);
          st_d = ST_DONE;
        end else begin
          raddr = ra_q; cur_d = rb_q; st_d = ST_UCHK;
        end
      end
      ST_UCHK: begin
        // rank of ra arrives now, fetch rank of rb
        rka_d = rdata_q; raddr = rb_q; st_d = ST_UWR;
      end
      ST_UWR: begin
        if (st_q == ST_UWR && cur_q == ra_q) begin
          // second pass: rb rank read is not needed, tie bump on ra
          waddr = ra_q; rwdata = rka_q + 1'b1; rwe = 1'b1;
          st_d = ST_DONE;
        end else if (rka_q < rdata_q) begin
          waddr = ra_q; pwdata = rb_q; pwe = 1'b1; st_d = ST_DONE;
        end else begin
          waddr = rb_q; pwdata = ra_q; pwe = 1'b1;
          if (rka_q == rdata_q && rka_q < RankMax) begin
            cur_d = ra_q; st_d = ST_UWR;
          end else begin
            st_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        pop_o = 1'b1; st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_INIT; idx_q <= '0; sum_q <= '0;
      dropped_q <= 1'b0; flag_q <= 1'b0; side_q <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d; sum_q <= sum_d;
      dropped_q <= dropped_d; flag_q <= flag_d; side_q <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; ra_q <= ra_d; rb_q <= rb_d; rka_q <= rka_d;
  end

  assign init_o                  = (st_q == ST_INIT);
  assign res_valid_o             = pop_o;
  assign res_o.edge_dropped        = dropped_q;
  assign res_o.dropped_total       = sum_q;
  assign res_o.vertex_out_of_range = flag_q;

endmodule

>>> hw/rtl/union_find_cycle_edge_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_cycle_edge_filter_core
// Disjoint-set cycle edge filter: rank union, full path compression.
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// item      in   start && !busy         item_i (ufcef_in_t)
// result    out  done_o strobe          result_o (ufcef_out_t)
// config    in   cfg_we_i               cfg_data_i (vertex_count)
//
// after reset a sweep initializes the parent and rank memories; busy is high
// throughout. an edge walks each endpoint to its root and compresses that path,
// then unions the two roots by rank; a clear sweeps the clamped vertex_count
// entries; a flagged item only returns its flag. the queue holds two commands
// and busy is high while it is full; the result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module union_find_cycle_edge_filter_core import ufcef_pkg::*; #(
  parameter int unsigned MaxVertices = MaxVerticesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ufcef_in_t         item_i,
  output logic              done_o,
  output ufcef_out_t        result_o,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_data_i
);

  localparam int unsigned VIdxW = $clog2(MaxVertices);

  logic [CountW-1:0] count_q;
  logic              full, empty, pop, init, take;
  ufcef_cmd_e        cmd;
  logic [VIdxW-1:0]  a, b;
  logic [CountW-1:0] cnt;
  logic signed [WeightW-1:0] w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountRst;
    end else if (cfg_we_i) begin
      count_q <= cfg_data_i;
    end
  end

  assign busy = full | init;
  assign take = start & ~busy;

  ufcef_front #(.MaxVertices(MaxVertices), .VIdxW(VIdxW)) u_front (
    .clk_i, .rst_ni, .take_i(take), .item_i, .count_i(count_q), .pop_i(pop),
    .full_o(full), .empty_o(empty), .cmd_o(cmd), .a_o(a), .b_o(b),
    .cnt_o(cnt), .w_o(w)
  );

  ufcef_back #(.MaxVertices(MaxVertices), .VIdxW(VIdxW)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .cmd_i(cmd), .a_i(a), .b_i(b),
    .cnt_i(cnt), .w_i(w), .pop_o(pop), .init_o(init),
    .res_valid_o(done_o), .res_o(result_o)
  );

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("pop from empty queue");
  a_no_take_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init |-> !take) else $error("item taken during init sweep");
  a_flag_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.vertex_out_of_range |-> !result_o.edge_dropped)
    else $error("flagged item also dropped");
`endif

endmodule
